[src/apt_pkg.sv]
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types and constants of the affine point transform core.
// ----------------------------------------------------------------------------
package apt_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_FULL = 2'd1;
    localparam logic [1:0] MODE_ROT  = 2'd2;
    localparam logic [1:0] MODE_INV  = 2'd3;

    typedef struct packed {
        logic [1:0]         mode;
        logic [3:0]         elem_index;
        logic signed [31:0] elem_value;
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic signed [31:0] z_in;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic signed [31:0] z_out;
        logic               overflow;
    } t_out_word;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_lane_en;

endpackage

[src/affine_point_transform_core.sv]
// ----------------------------------------------------------------------------
// affine_point_transform_core
// 4x4 affine point transform in signed fixed point, one point per cycle unless the output stalls.
// ----------------------------------------------------------------------------
//  channel | handshake           | word
//  --------+---------------------+-------------------------------------------
//  input   | i_valid / o_ready   | i_data : mode, elem_index, elem_value, xyz
//  output  | o_valid / i_ready   | o_data : x_out, y_out, z_out, overflow
//
//  Accepts one word per cycle while o_ready is high; a point's valid bit runs
//  from r_vld[0] to r_vld[4] (o_valid). Three lanes of three 32x32 multipliers
//  set the pipeline: operand select, multiply, round, row sum, saturate and merge.
//  A load word updates the matrix at its accept edge and yields no output.
//  Reset restores the identity matrix and empties the pipeline.
//  Stages fill bubbles while the output stalls; o_ready drops only when full.
// ----------------------------------------------------------------------------
module affine_point_transform_core #(
    parameter int FRAC_BITS = apt_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  apt_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output apt_pkg::t_out_word o_data
);
    import apt_pkg::*;

    localparam int SW = 64 - FRAC_BITS + 2;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

    logic signed [31:0]  r_mat [16];
    logic signed [31:0]  r_pt  [3];
    logic signed [31:0]  r_el  [3][3];
    logic signed [31:0]  r_tr  [3];
    logic [4:0]          r_vld;
    logic [4:0]          w_en;
    logic                w_acc;
    t_lane_en            w_lane_en;
    logic signed [SW-1:0] w_sum [3];

    assign w_en[4] = !r_vld[4] || i_ready;
    assign w_en[3] = !r_vld[3] || w_en[4];
    assign w_en[2] = !r_vld[2] || w_en[3];
    assign w_en[1] = !r_vld[1] || w_en[2];
    assign w_en[0] = !r_vld[0] || w_en[1];

    assign o_ready = w_en[0];
    assign o_valid = r_vld[4];
    assign w_acc   = i_valid && o_ready;

    assign w_lane_en.s2 = w_en[1];
    assign w_lane_en.s3 = w_en[2];
    assign w_lane_en.s4 = w_en[3];

    // matrix store, identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_mat[i] <= (i % 5 == 0) ? ONE : 32'sd0;
            end
        end else if (w_acc && i_data.mode == MODE_LOAD) begin
            r_mat[i_data.elem_index] <= i_data.elem_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= w_acc && i_data.mode != MODE_LOAD;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
            if (w_en[3]) r_vld[3] <= r_vld[2];
            if (w_en[4]) r_vld[4] <= r_vld[3];
        end
    end

    // operand select: column-major, transposed for inverse rotate
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_pt[0] <= i_data.x_in;
            r_pt[1] <= i_data.y_in;
            r_pt[2] <= i_data.z_in;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_el[r][c] <= (i_data.mode == MODE_INV) ? r_mat[r*4 + c]
                                                            : r_mat[c*4 + r];
                end
                r_tr[r] <= (i_data.mode == MODE_FULL) ? r_mat[12 + r] : 32'sd0;
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        apt_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (w_lane_en),
            .i_pt   (r_pt),
            .i_elem (r_el[g]),
            .i_tr   (r_tr[g]),
            .o_sum  (w_sum[g])
        );
    end

    apt_merge #(
        .FRAC_BITS (FRAC_BITS)
    ) u_merge (
        .i_clk  (i_clk),
        .i_en   (w_en[4]),
        .i_sum  (w_sum),
        .o_data (o_data)
    );

endmodule

[src/apt_lane.sv]
// ----------------------------------------------------------------------------
// apt_lane
// One output coordinate: three products, rounding, and the row sum.
// ----------------------------------------------------------------------------
module apt_lane #(
    parameter int FRAC_BITS = apt_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  apt_pkg::t_lane_en  i_en,
    input  logic signed [31:0] i_pt   [3],
    input  logic signed [31:0] i_elem [3],
    input  logic signed [31:0] i_tr,
    output logic signed [63-FRAC_BITS+2:0] o_sum
);
    import apt_pkg::*;

    localparam int RW = 64 - FRAC_BITS;
    localparam int SW = RW + 2;

    logic signed [63:0]    r_prod [3];
    logic signed [RW-1:0]  r_rnd  [3];
    logic signed [31:0]    r_tr2;
    logic signed [31:0]    r_tr3;
    logic signed [SW-1:0]  r_sum;
    logic signed [64:0]    w_bias [3];
    logic signed [64:0]    w_shr  [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_bias[c] = $signed({r_prod[c][63], r_prod[c]})
                      + (65'sd1 <<< (FRAC_BITS - 1));
            w_shr[c]  = w_bias[c] >>> FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            for (int c = 0; c < 3; c++) begin
                r_prod[c] <= i_pt[c] * i_elem[c];
            end
            r_tr2 <= i_tr;
        end
        if (i_en.s3) begin
            for (int c = 0; c < 3; c++) begin
                r_rnd[c] <= w_shr[c][RW-1:0];
            end
            r_tr3 <= r_tr2;
        end
        if (i_en.s4) begin
            r_sum <= {{2{r_rnd[0][RW-1]}}, r_rnd[0]}
                   + {{2{r_rnd[1][RW-1]}}, r_rnd[1]}
                   + {{2{r_rnd[2][RW-1]}}, r_rnd[2]}
                   + {{(SW-32){r_tr3[31]}}, r_tr3};
        end
    end

    assign o_sum = r_sum;

endmodule

[src/apt_merge.sv]
// ----------------------------------------------------------------------------
// apt_merge
// Saturate the lane sums, combine overflow, and hold the output word.
// ----------------------------------------------------------------------------
module apt_merge #(
    parameter int FRAC_BITS = apt_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [63-FRAC_BITS+2:0] i_sum [3],
    output apt_pkg::t_out_word             o_data
);
    import apt_pkg::*;

    localparam int SW = 64 - FRAC_BITS + 2;
    localparam logic signed [SW-1:0] MAXV = {{(SW-32){1'b0}}, 32'h7FFF_FFFF};
    localparam logic signed [SW-1:0] MINV = {{(SW-32){1'b1}}, 32'h8000_0000};

    logic signed [31:0] w_sat [3];
    logic [2:0]         w_ovf;
    t_out_word          r_out;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            if (i_sum[r] > MAXV) begin
                w_sat[r] = 32'sh7FFF_FFFF;
                w_ovf[r] = 1'b1;
            end else if (i_sum[r] < MINV) begin
                w_sat[r] = -32'sh8000_0000;
                w_ovf[r] = 1'b1;
            end else begin
                w_sat[r] = i_sum[r][31:0];
                w_ovf[r] = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out.x_out    <= w_sat[0];
            r_out.y_out    <= w_sat[1];
            r_out.z_out    <= w_sat[2];
            r_out.overflow <= |w_ovf;
        end
    end

    assign o_data = r_out;

endmodule

[src/apt_checker.sv]
// ----------------------------------------------------------------------------
// apt_checker
// Port-level checks of the affine point transform core.
// ----------------------------------------------------------------------------
module apt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input apt_pkg::t_in_word  i_data,
    input logic               o_valid,
    input logic               i_ready,
    input apt_pkg::t_out_word o_data
);
    import apt_pkg::*;

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid right after reset");

    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("stalled output word changed");

    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

    a_ovf_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.overflow |->
            o_data.x_out == 32'sh7FFF_FFFF || o_data.x_out == -32'sh8000_0000 ||
            o_data.y_out == 32'sh7FFF_FFFF || o_data.y_out == -32'sh8000_0000 ||
            o_data.z_out == 32'sh7FFF_FFFF || o_data.z_out == -32'sh8000_0000)
        else $error("overflow set with no saturated coordinate");

endmodule

bind affine_point_transform_core apt_checker u_apt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

[tb/tb_affine_point_transform_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_affine_point_transform_core
// Self-checking bench for the affine point transform core. A local copy of
// the 4x4 matrix follows every load word, and each accepted point word is
// turned into the expected output word: rounded products, optional
// translation, saturation and overflow flag. Directed cases cover extremes,
// all modes, the unused bottom row, round-half-up and saturation. Random
// matrix sets and point streams follow, with idle cycles and backpressure on
// both sides.
// ----------------------------------------------------------------------------
module tb_affine_point_transform_core;

    import apt_pkg::*;

    localparam int                 FRAC_BITS  = FRAC_BITS_DEF;
    localparam int                 TIMEOUT_NS = 2_000_000;
    localparam int                 ERR_PRINTS = 200;
    localparam longint             SAT_MAX    = 64'sd2147483647;
    localparam longint             SAT_MIN    = -64'sd2147483648;
    localparam logic signed [31:0] Q_MAX      = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN      = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE      = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] Q_HALF_LSB = 32'sd1 <<< (FRAC_BITS - 1);

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    t_in_word   i_data  = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    t_out_word  o_data;

    logic signed [31:0] matrix_q [16];
    t_out_word          pending_points [$];
    int                 err_count = 0;
    bit                 quiet_tx  = 1'b0;
    bit                 quiet_rx  = 1'b0;
    int                 hold_req  = 0;
    int                 hold_left = 0;

    affine_point_transform_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= ERR_PRINTS) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    task automatic reset_matrix();
        foreach (matrix_q[i]) begin
            matrix_q[i] = '0;
        end
        matrix_q[0]  = Q_ONE;
        matrix_q[5]  = Q_ONE;
        matrix_q[10] = Q_ONE;
        matrix_q[15] = Q_ONE;
    endtask

    function automatic t_out_word predict_point(t_in_word w);
        logic signed [31:0] coord [3];
        logic signed [31:0] res [3];
        longint             prod;
        longint             acc;
        int                 idx;
        logic               ovf;
        t_out_word          o;
        coord[0] = w.x_in;
        coord[1] = w.y_in;
        coord[2] = w.z_in;
        ovf = 1'b0;
        for (int r = 0; r < 3; r++) begin
            acc = 0;
            for (int c = 0; c < 3; c++) begin
                idx  = (w.mode == MODE_INV) ? r * 4 + c : c * 4 + r;
                prod = longint'(coord[c]) * longint'(matrix_q[idx]);
                acc += (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            end
            if (w.mode == MODE_FULL) begin
                acc += longint'(matrix_q[12 + r]);
            end
            if (acc > SAT_MAX) begin
                acc = SAT_MAX;
                ovf = 1'b1;
            end else if (acc < SAT_MIN) begin
                acc = SAT_MIN;
                ovf = 1'b1;
            end
            res[r] = acc[31:0];
        end
        o.x_out    = res[0];
        o.y_out    = res[1];
        o.z_out    = res[2];
        o.overflow = ovf;
        return o;
    endfunction

    function automatic logic signed [31:0] rand_fixed(int span);
        case ($urandom_range(9))
            0: return $urandom;
            1: begin
                case ($urandom_range(6))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return 32'sd0;
                    3: return 32'sd1;
                    4: return -32'sd1;
                    5: return Q_ONE;
                    default: return -Q_ONE;
                endcase
            end
            default: return $signed($urandom) >>> (31 - span);
        endcase
    endfunction

    function automatic t_in_word make_load(logic [3:0] idx, logic signed [31:0] val);
        t_in_word w;
        w.mode       = MODE_LOAD;
        w.elem_index = idx;
        w.elem_value = val;
        w.x_in       = $urandom;
        w.y_in       = $urandom;
        w.z_in       = $urandom;
        return w;
    endfunction

    function automatic t_in_word make_point(logic [1:0] mode, logic signed [31:0] x,
                                            logic signed [31:0] y, logic signed [31:0] z);
        t_in_word w;
        w.mode       = mode;
        w.elem_index = 4'($urandom);
        w.elem_value = $urandom;
        w.x_in       = x;
        w.y_in       = y;
        w.z_in       = z;
        return w;
    endfunction

    function automatic t_in_word random_point();
        return make_point(2'($urandom_range(MODE_FULL, MODE_INV)),
                          rand_fixed(28), rand_fixed(28), rand_fixed(28));
    endfunction

    function automatic t_in_word random_word();
        if ($urandom_range(3) == 0) begin
            return make_load(4'($urandom), rand_fixed(18));
        end
        return random_point();
    endfunction

    // Present one word, hold it until accepted, then update the prediction.
    task automatic send_word(t_in_word w);
        if (!quiet_tx) begin
            while ($urandom_range(99) < 20) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b1;
        i_data  <= w;
        do @(posedge i_clk); while (!o_ready);
        if (w.mode == MODE_LOAD) begin
            matrix_q[w.elem_index] = w.elem_value;
        end else begin
            pending_points.push_back(predict_point(w));
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_points.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (quiet_rx) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 20);
        end
    end

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_points.size() == 0) begin
                report_mismatch($sformatf("output word %h with none pending", o_data));
            end else begin
                want = pending_points.pop_front();
                if (o_data.x_out !== want.x_out) begin
                    report_mismatch($sformatf("x_out got %h expected %h",
                                              o_data.x_out, want.x_out));
                end
                if (o_data.y_out !== want.y_out) begin
                    report_mismatch($sformatf("y_out got %h expected %h",
                                              o_data.y_out, want.y_out));
                end
                if (o_data.z_out !== want.z_out) begin
                    report_mismatch($sformatf("z_out got %h expected %h",
                                              o_data.z_out, want.z_out));
                end
                if (o_data.overflow !== want.overflow) begin
                    report_mismatch($sformatf("overflow got %b expected %b",
                                              o_data.overflow, want.overflow));
                end
            end
        end
    end

    task automatic test_identity_points();
        send_word(make_point(MODE_FULL, Q_MAX, Q_MIN, 32'sd0));
        send_word(make_point(MODE_ROT, Q_MIN, Q_MAX, -32'sd1));
        send_word(make_point(MODE_INV, 32'sd1, -32'sd1, Q_MAX));
    endtask

    task automatic test_translation_saturation();
        send_word(make_load(4'd12, Q_MAX));
        send_word(make_load(4'd13, Q_MIN));
        send_word(make_point(MODE_FULL, Q_ONE, -Q_ONE, 32'sd5));
        send_word(make_point(MODE_ROT, Q_ONE, -Q_ONE, 32'sd5));
    endtask

    task automatic test_bottom_row();
        send_word(make_load(4'd3, Q_MAX));
        send_word(make_load(4'd7, Q_MIN));
        send_word(make_load(4'd11, 32'sh1234_5678));
        send_word(make_load(4'd15, 32'sd0));
        send_word(make_point(MODE_FULL, -Q_ONE, Q_ONE, Q_MAX));
    endtask

    task automatic test_round_half_up();
        send_word(make_load(4'd12, 32'sd0));
        send_word(make_load(4'd13, 32'sd0));
        send_word(make_load(4'd1, 32'sd1));
        send_word(make_point(MODE_FULL, Q_HALF_LSB, 32'sd7, 32'sd0));
        send_word(make_point(MODE_FULL, -Q_HALF_LSB, 32'sd7, 32'sd0));
        send_word(make_point(MODE_INV, 32'sd3, -Q_HALF_LSB, 32'sd0));
    endtask

    task automatic test_product_overflow();
        send_word(make_load(4'd0, Q_MIN));
        send_word(make_point(MODE_ROT, Q_MIN, 32'sd0, 32'sd0));
    endtask

    task automatic test_streaming(int n_items);
        quiet_tx = 1'b1;
        quiet_rx = 1'b1;
        repeat (n_items) send_word(random_word());
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
    endtask

    // Stall the output long enough that the core fills and drops o_ready.
    task automatic test_backpressure(int n_items);
        quiet_tx = 1'b1;
        hold_req = 120;
        repeat (n_items) send_word(random_point());
        quiet_tx = 1'b0;
    endtask

    task automatic test_pause_drain();
        repeat (12) send_word(random_word());
        wait_drained();
        repeat (12) send_word(random_word());
    endtask

    task automatic test_random_sets(int n_items);
        int sent;
        int n_load;
        int n_pts;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(4) == 0) begin
                for (int i = 0; i < 16; i++) begin
                    send_word(make_load(4'(i), rand_fixed(18)));
                end
                sent += 16;
            end else begin
                n_load = $urandom_range(3);
                repeat (n_load) send_word(make_load(4'($urandom), rand_fixed(18)));
                sent += n_load;
            end
            n_pts = $urandom_range(1, 12);
            repeat (n_pts) send_word(random_point());
            sent += n_pts;
        end
    endtask

    initial begin
        reset_matrix();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_identity_points();
        test_translation_saturation();
        test_bottom_row();
        test_round_half_up();
        test_product_overflow();
        test_streaming(200);
        test_backpressure(40);
        test_pause_drain();
        test_random_sets(920);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
